// ----- sv/ias_accumulator_execute_assert.svh -----
// Assertion macros for the accumulator execute unit checker.
// Included by the checker file; depends on nothing else.
`ifndef IAS_ACCUMULATOR_EXECUTE_ASSERT_SVH
`define IAS_ACCUMULATOR_EXECUTE_ASSERT_SVH

// Plain clocked property, switched off while reset is asserted.
`define IAE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("iae check failed");

// Condition in one cycle implies a consequence in the next.
`define IAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("iae check failed");

`endif

// ----- sv/iae_pkg.sv -----
// Shared types, constants and helpers for the accumulator execute unit.
// No dependencies; imported by every module of the block except iae_ram.
`timescale 1ns / 1ps

package iae_pkg;

  localparam int WORD_W        = 32;
  localparam int ADDR_W        = 10;
  localparam int PC_W          = 10;
  localparam int ACT_W         = 4;
  localparam int ALU_W         = WORD_W + 1;
  localparam int CNT_W         = 5;
  localparam int MEM_DEPTH_DEF = 1024;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 80;

  typedef enum logic [ACT_W-1:0] {
    ACT_PRELOAD  = 4'd0,
    ACT_NOP      = 4'd1,
    ACT_LDMQ     = 4'd2,
    ACT_STORE    = 4'd3,
    ACT_LOAD     = 4'd4,
    ACT_LDNEG    = 4'd5,
    ACT_LDABS    = 4'd6,
    ACT_LDNEGABS = 4'd7,
    ACT_ACMQ     = 4'd8,
    ACT_ADD      = 4'd9,
    ACT_ADDABS   = 4'd10,
    ACT_SUB      = 4'd11,
    ACT_SUBABS   = 4'd12,
    ACT_MUL      = 4'd13,
    ACT_DIV      = 4'd14
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_DABS,
    ST_DIV,
    ST_QFIX,
    ST_RFIX,
    ST_DONE
  } state_e;

  // sequencer -> datapath
  typedef struct packed {
    logic take;
    logic ram_re;
    logic exec;
    logic mul_step;
    logic dabs;
    logic div_step;
    logic qfix;
    logic rfix;
    logic finish;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_valid;
    logic is_mul;
    logic is_div;
    logic div_zero;
    logic cnt_last;
    logic out_free;
  } stat_t;

  // Address modulo depth by compare-subtract; address < 1024 and depth >= 16,
  // so six steps bring it below the depth.
  function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] addr,
                                                  input logic [16:0] depth);
    logic [23:0] rem;
    logic [23:0] lim;
    rem = 24'(addr);
    for (int k = 5; k >= 0; k--) begin
      lim = 24'(depth) << k;
      if (rem >= lim) rem = rem - lim;
    end
    return rem[ADDR_W-1:0];
  endfunction

endpackage

// ----- sv/iae_ram.sv -----
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module iae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- sv/iae_alu.sv -----
// Shared 33-bit adder/subtractor used by every arithmetic step.
// Depends on iae_pkg for widths.
`timescale 1ns / 1ps

module iae_alu (
  input  logic [iae_pkg::ALU_W-1:0] a_i,
  input  logic [iae_pkg::ALU_W-1:0] b_i,
  input  logic                      sub_i,
  output logic [iae_pkg::ALU_W-1:0] sum_o
);
  import iae_pkg::*;

  assign sum_o = a_i + (sub_i ? ~b_i : b_i) + ALU_W'(sub_i);

endmodule

// ----- sv/iae_ctrl.sv -----
// Sequencer for the execute unit: walks one instruction through read,
// execute and the multi-cycle multiply/divide loops. Depends on iae_pkg.
`timescale 1ns / 1ps

module iae_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iae_pkg::stat_t stat_i,
  output iae_pkg::ctrl_t ctrl_o,
  output logic           ready_o
);
  import iae_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (stat_i.in_valid) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (stat_i.is_mul)                         state_d = ST_MUL;
        else if (stat_i.is_div && !stat_i.div_zero) state_d = ST_DABS;
        else                                        state_d = ST_DONE;
      end
      ST_MUL:  if (stat_i.cnt_last) state_d = ST_DONE;
      ST_DABS: state_d = ST_DIV;
      ST_DIV:  if (stat_i.cnt_last) state_d = ST_QFIX;
      ST_QFIX: state_d = ST_RFIX;
      ST_RFIX: state_d = ST_DONE;
      ST_DONE: if (stat_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o  = '0;
    ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ready_o     = 1'b1;
        ctrl_o.take = stat_i.in_valid;
      end
      ST_READ: ctrl_o.ram_re   = 1'b1;
      ST_EXEC: ctrl_o.exec     = 1'b1;
      ST_MUL:  ctrl_o.mul_step = 1'b1;
      ST_DABS: ctrl_o.dabs     = 1'b1;
      ST_DIV:  ctrl_o.div_step = 1'b1;
      ST_QFIX: ctrl_o.qfix     = 1'b1;
      ST_RFIX: ctrl_o.rfix     = 1'b1;
      ST_DONE: ctrl_o.finish   = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- sv/ias_accumulator_execute.sv -----
// Accumulator execute unit top level: AC/MQ/PC datapath, word memory,
// output register. Depends on iae_pkg, iae_ram, iae_alu and iae_ctrl.
//
// Usage:
//   One decoded instruction arrives per transfer on s_axis; every instruction
//   gives exactly one result transfer on m_axis carrying AC, MQ, PC and the
//   divide error flag as they stand after that instruction.
//   Each instruction passes through the idle, memory read, execute and done
//   states; multiply adds 32 shift-add steps of the shared adder, and divide
//   adds the operand magnitudes, 32 restoring steps and two sign fix-ups.
//   A zero-divisor divide skips the loop and only sets the error flag.
//   The shared adder and the single memory port set this sequence; one
//   instruction is in flight at a time, so the next one is taken only after
//   the last one has finished.
//   s_axis_tready is high only while the sequencer is idle. A finished result
//   sits in the output register, so the next instruction can be taken while
//   it waits; if the receiver still stalls when that one completes, the
//   sequencer holds in its final state.
//   Reset clears AC, MQ, PC and the output valid; memory content is
//   undefined until written by preload or store.
`timescale 1ns / 1ps

module ias_accumulator_execute #(
  parameter int MEM_DEPTH = iae_pkg::MEM_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] action, [13:4] word_address, [45:14] preload_value, [47:46] zero
  input  logic [iae_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] accumulator, [63:32] quotient_register, [73:64] program_count,
  // [74] divide_error, [79:75] zero
  output logic [iae_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import iae_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] PC_LAST = AW'(MEM_DEPTH - 1);

  ctrl_t ctrl;
  stat_t stat;

  // architectural state
  logic [WORD_W-1:0] ac_q, ac_d, mq_q, mq_d;
  logic [AW-1:0]     pc_q, pc_d;
  logic              err_q, err_d;
  // instruction and iteration registers
  action_e           act_q, act_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [WORD_W-1:0] pre_q, pre_d;
  logic [WORD_W-1:0] rem_q, rem_d, wrk_q, wrk_d, opd_q, opd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              qneg_q, qneg_d, rneg_q, rneg_d;
  // output register
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_ac_q, out_ac_d, out_mq_q, out_mq_d;
  logic [PC_W-1:0]   out_pc_q, out_pc_d;
  logic              out_err_q, out_err_d;

  logic [WORD_W-1:0] m;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic [WORD_W-1:0] prod_nxt;
  logic [AW-1:0]     pc_nxt;

  iae_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .ready_o (s_axis_tready)
  );

  iae_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (ctrl.ram_re),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (ram_wdata),
    .rdata_o (m)
  );

  iae_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign stat.in_valid = s_axis_tvalid;
  assign stat.is_mul   = (act_q == ACT_MUL);
  assign stat.is_div   = (act_q == ACT_DIV);
  assign stat.div_zero = (m == '0);
  assign stat.cnt_last = (cnt_q == '1);
  assign stat.out_free = !out_valid_q || m_axis_tready;

  assign prod_nxt = wrk_q[0] ? alu_sum[WORD_W-1:0] : rem_q;
  assign pc_nxt   = (act_q == ACT_PRELOAD) ? pc_q :
                    (pc_q == PC_LAST) ? '0 : pc_q + AW'(1);

  always_comb begin
    ac_d        = ac_q;
    mq_d        = mq_q;
    pc_d        = pc_q;
    err_d       = err_q;
    act_d       = act_q;
    addr_d      = addr_q;
    pre_d       = pre_q;
    rem_d       = rem_q;
    wrk_d       = wrk_q;
    opd_d       = opd_q;
    cnt_d       = cnt_q;
    qneg_d      = qneg_q;
    rneg_d      = rneg_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ac_d    = out_ac_q;
    out_mq_d    = out_mq_q;
    out_pc_d    = out_pc_q;
    out_err_d   = out_err_q;
    ram_we      = 1'b0;
    ram_wdata   = pre_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    if (ctrl.take) begin
      act_d  = action_e'(s_axis_tdata[3:0]);
      addr_d = AW'(wrap_addr(s_axis_tdata[13:4], 17'(MEM_DEPTH)));
      pre_d  = s_axis_tdata[45:14];
      err_d  = 1'b0;
    end

    if (ctrl.exec) begin
      case (act_q)
        ACT_PRELOAD: ram_we = 1'b1;
        ACT_STORE: begin
          ram_we    = 1'b1;
          ram_wdata = ac_q;
        end
        ACT_LDMQ: mq_d = m;
        ACT_LOAD: begin
          alu_b = {1'b0, m};
          ac_d  = alu_sum[WORD_W-1:0];
        end
        ACT_LDNEG: begin
          alu_b   = {1'b0, m};
          alu_sub = 1'b1;
          ac_d    = alu_sum[WORD_W-1:0];
        end
        ACT_LDABS: begin
          alu_b   = {1'b0, m};
          alu_sub = m[WORD_W-1];
          ac_d    = alu_sum[WORD_W-1:0];
        end
        ACT_LDNEGABS: begin
          alu_b   = {1'b0, m};
          alu_sub = !m[WORD_W-1];
          ac_d    = alu_sum[WORD_W-1:0];
        end
        ACT_ACMQ: ac_d = mq_q;
        ACT_ADD: begin
          alu_a = {1'b0, ac_q};
          alu_b = {1'b0, m};
          ac_d  = alu_sum[WORD_W-1:0];
        end
        ACT_ADDABS: begin
          alu_a   = {1'b0, ac_q};
          alu_b   = {1'b0, m};
          alu_sub = m[WORD_W-1];
          ac_d    = alu_sum[WORD_W-1:0];
        end
        ACT_SUB: begin
          alu_a   = {1'b0, ac_q};
          alu_b   = {1'b0, m};
          alu_sub = 1'b1;
          ac_d    = alu_sum[WORD_W-1:0];
        end
        ACT_SUBABS: begin
          alu_a   = {1'b0, ac_q};
          alu_b   = {1'b0, m};
          alu_sub = !m[WORD_W-1];
          ac_d    = alu_sum[WORD_W-1:0];
        end
        ACT_MUL: begin
          rem_d = '0;
          wrk_d = mq_q;
          opd_d = m;
          cnt_d = '0;
        end
        ACT_DIV: begin
          if (m == '0) begin
            err_d = 1'b1;
          end else begin
            // dividend magnitude; signs kept for the fix-up steps
            alu_b   = {1'b0, ac_q};
            alu_sub = ac_q[WORD_W-1];
            wrk_d   = alu_sum[WORD_W-1:0];
            rneg_d  = ac_q[WORD_W-1];
            qneg_d  = ac_q[WORD_W-1] ^ m[WORD_W-1];
            rem_d   = '0;
          end
        end
        default: ;
      endcase
    end

    // shift-add multiply, low word only
    if (ctrl.mul_step) begin
      alu_a = {1'b0, rem_q};
      alu_b = {1'b0, opd_q};
      rem_d = prod_nxt;
      wrk_d = wrk_q >> 1;
      opd_d = opd_q << 1;
      cnt_d = cnt_q + CNT_W'(1);
      if (stat.cnt_last) ac_d = prod_nxt;
    end

    if (ctrl.dabs) begin
      alu_b   = {1'b0, m};
      alu_sub = m[WORD_W-1];
      opd_d   = alu_sum[WORD_W-1:0];
      cnt_d   = '0;
    end

    // restoring divide: quotient bits shift into wrk as dividend shifts out
    if (ctrl.div_step) begin
      alu_a   = {rem_q, wrk_q[WORD_W-1]};
      alu_b   = {1'b0, opd_q};
      alu_sub = 1'b1;
      rem_d   = alu_sum[ALU_W-1] ? {rem_q[WORD_W-2:0], wrk_q[WORD_W-1]}
                                 : alu_sum[WORD_W-1:0];
      wrk_d   = {wrk_q[WORD_W-2:0], !alu_sum[ALU_W-1]};
      cnt_d   = cnt_q + CNT_W'(1);
    end

    if (ctrl.qfix) begin
      alu_b   = {1'b0, wrk_q};
      alu_sub = qneg_q;
      mq_d    = alu_sum[WORD_W-1:0];
    end

    if (ctrl.rfix) begin
      alu_b   = {1'b0, rem_q};
      alu_sub = rneg_q;
      ac_d    = alu_sum[WORD_W-1:0];
    end

    if (ctrl.finish) begin
      pc_d        = pc_nxt;
      out_valid_d = 1'b1;
      out_ac_d    = ac_q;
      out_mq_d    = mq_q;
      out_pc_d    = PC_W'(pc_nxt);
      out_err_d   = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_q        <= '0;
      mq_q        <= '0;
      pc_q        <= '0;
      err_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ac_q        <= ac_d;
      mq_q        <= mq_d;
      pc_q        <= pc_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    addr_q    <= addr_d;
    pre_q     <= pre_d;
    rem_q     <= rem_d;
    wrk_q     <= wrk_d;
    opd_q     <= opd_d;
    qneg_q    <= qneg_d;
    rneg_q    <= rneg_d;
    out_ac_q  <= out_ac_d;
    out_mq_q  <= out_mq_d;
    out_pc_q  <= out_pc_d;
    out_err_q <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_err_q, out_pc_q, out_mq_q, out_ac_q};

endmodule

// ----- sv/iae_checker.sv -----
// Port-level checker for the accumulator execute unit, bound to the top.
// Depends on iae_pkg and ias_accumulator_execute_assert.svh.
`timescale 1ns / 1ps
`include "ias_accumulator_execute_assert.svh"

module iae_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [iae_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [iae_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import iae_pkg::*;

  // stalled result transfer keeps its payload
  `IAE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // stalled input transfer keeps its payload
  `IAE_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata))
  // one instruction at a time: busy right after an input transfer
  `IAE_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a new result only appears after the sequencer was busy
  `IAE_ASSERT(a_result_after_work, clk_i, rst_ni, !$rose(m_axis_tvalid) || !$past(s_axis_tready))
  // padding bits of the result stay clear
  `IAE_ASSERT(a_pad_zero, clk_i, rst_ni, !m_axis_tvalid || (m_axis_tdata[79:75] == 5'b0))

endmodule

bind ias_accumulator_execute iae_checker u_iae_checker (.*);

// ----- tb/sv/iae_result_checker.sv -----
// Result checker for the accumulator execute unit: watches both stream channels,
// predicts AC, MQ, PC and the divide error flag per instruction, and compares.
// Depends on iae_pkg.
`timescale 1ns / 1ps

module iae_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [iae_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [iae_pkg::OUT_TDATA_W-1:0] out_data_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              result_count_o,
  output int                              div_zero_count_o
);

  import iae_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] mq;
    logic [PC_W-1:0]   pc;
    logic              div_err;
  } machine_view_t;

  machine_view_t     outstanding_views[$];
  machine_view_t     want;
  machine_view_t     got;
  logic [WORD_W-1:0] word_mem [0:MEM_DEPTH_DEF-1];
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] mq_r;
  logic [PC_W-1:0]   pc_r;
  int                fails;
  int                results;
  int                div_zeros;

  // Applies one instruction to the shadow machine and returns what it shows after.
  function automatic machine_view_t run_instruction(input logic [ACT_W-1:0]  act,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [WORD_W-1:0] value);
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] mag;
    longint            num;
    longint            den;
    logic              err;
    m   = word_mem[addr];
    mag = m[WORD_W-1] ? -m : m;
    err = 1'b0;
    case (act)
      ACT_PRELOAD:  word_mem[addr] = value;
      ACT_LDMQ:     mq_r = m;
      ACT_STORE:    word_mem[addr] = acc_r;
      ACT_LOAD:     acc_r = m;
      ACT_LDNEG:    acc_r = -m;
      ACT_LDABS:    acc_r = mag;
      ACT_LDNEGABS: acc_r = -mag;
      ACT_ACMQ:     acc_r = mq_r;
      ACT_ADD:      acc_r = acc_r + m;
      ACT_ADDABS:   acc_r = acc_r + mag;
      ACT_SUB:      acc_r = acc_r - m;
      ACT_SUBABS:   acc_r = acc_r - mag;
      ACT_MUL:      acc_r = mq_r * m;
      ACT_DIV: begin
        if (m == '0) begin
          err = 1'b1;
        end else begin
          // 64-bit so that the most negative word over -1 does not overflow
          num   = $signed(acc_r);
          den   = $signed(m);
          mq_r  = 32'(num / den);
          acc_r = 32'(num % den);
        end
      end
      default: ;
    endcase
    if (act != ACT_PRELOAD) pc_r = pc_r + 1'b1;
    return '{acc_r, mq_r, pc_r, err};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_r     = '0;
      mq_r      = '0;
      pc_r      = '0;
      fails     = 0;
      results   = 0;
      div_zeros = 0;
      outstanding_views.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        outstanding_views.push_back(run_instruction(in_data_i[3:0], in_data_i[13:4],
                                                    in_data_i[45:14]));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{out_data_i[31:0], out_data_i[63:32], out_data_i[73:64], out_data_i[74]};
        if (outstanding_views.size() == 0) begin
          $error("result transfer with no instruction outstanding");
          fails++;
        end else begin
          want = outstanding_views.pop_front();
          results++;
          if (want.div_err) div_zeros++;
          if (got.acc !== want.acc) begin
            $error("accumulator: expected %0d, got %0d", $signed(want.acc), $signed(got.acc));
            fails++;
          end
          if (got.mq !== want.mq) begin
            $error("quotient_register: expected %0d, got %0d", $signed(want.mq),
                   $signed(got.mq));
            fails++;
          end
          if (got.pc !== want.pc) begin
            $error("program_count: expected %0d, got %0d", want.pc, got.pc);
            fails++;
          end
          if (got.div_err !== want.div_err) begin
            $error("divide_error: expected %0b, got %0b", want.div_err, got.div_err);
            fails++;
          end
        end
      end
    end
    fail_count_o     <= fails;
    pending_o        <= outstanding_views.size();
    result_count_o   <= results;
    div_zero_count_o <= div_zeros;
  end

endmodule

// ----- tb/sv/tb_ias_accumulator_execute.sv -----
// Testbench top for the accumulator execute unit: clock, reset, instruction
// stimulus, result-side back-pressure and the verdict. Depends on iae_pkg,
// ias_accumulator_execute and iae_result_checker.
`timescale 1ns / 1ps

module tb_ias_accumulator_execute;

  import iae_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE   = 4'd15; // unused code, behaves as nop
  localparam int               RAND_ITEMS  = 924;
  localparam int               HOLD_CYCLES = 150;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int                     fail_count;
  int                     pending;
  int                     result_count;
  int                     div_zero_count;
  int                     sent_count = 0;
  bit                     calm       = 1'b0;
  bit                     hold_done  = 1'b0;
  bit                     is_written [0:MEM_DEPTH_DEF-1];
  logic [ADDR_W-1:0]      written_addrs[$];

  ias_accumulator_execute dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  iae_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .result_count_o   (result_count),
    .div_zero_count_o (div_zero_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("ias_accumulator_execute test failed");
    $finish;
  end

  // Result side: random stalls, none while calm, plus one long hold-off so the
  // block fills up and drops s_axis_tready.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_count >= 700) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  // Offers one instruction and returns at the edge where it is transferred.
  task automatic send_instr(input logic [ACT_W-1:0]  act,
                            input logic [ADDR_W-1:0] addr,
                            input logic [WORD_W-1:0] value);
    if (!calm && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, value, addr, act};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    if ((act == ACT_PRELOAD || act == ACT_STORE) && !is_written[addr]) begin
      is_written[addr] = 1'b1;
      written_addrs.push_back(addr);
    end
  endtask

  initial begin
    logic [ACT_W-1:0]  act;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] value;
    int                roll;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every action, wrap cases of negate/abs/divide
    send_instr(ACT_PRELOAD, 10'd0, 32'h7fff_ffff);
    send_instr(ACT_PRELOAD, 10'd1023, 32'h8000_0000);
    send_instr(ACT_PRELOAD, 10'd1, 32'hffff_ffff);
    send_instr(ACT_PRELOAD, 10'd2, 32'h0000_0000);
    send_instr(ACT_PRELOAD, 10'h2aa, 32'd7);
    send_instr(ACT_PRELOAD, 10'h155, -32'sd3);
    send_instr(ACT_LOAD, 10'd0, '0);
    send_instr(ACT_ADD, 10'd0, '0);
    send_instr(ACT_LDNEG, 10'd1023, '0);
    send_instr(ACT_LDABS, 10'd1023, '0);
    send_instr(ACT_LDNEGABS, 10'd1, '0);
    send_instr(ACT_LDMQ, 10'd1, '0);
    send_instr(ACT_MUL, 10'd1023, '0);
    send_instr(ACT_ACMQ, 10'd0, '0);
    send_instr(ACT_ADDABS, 10'd1023, '0);
    send_instr(ACT_SUB, 10'd0, '0);
    send_instr(ACT_SUBABS, 10'd1, '0);
    send_instr(ACT_LOAD, 10'd1023, '0);
    send_instr(ACT_DIV, 10'd1, '0);
    send_instr(ACT_DIV, 10'd2, '0);
    send_instr(ACT_LOAD, 10'h2aa, '0);
    send_instr(ACT_DIV, 10'h155, '0);
    send_instr(ACT_STORE, 10'd5, '0);
    send_instr(ACT_LOAD, 10'd5, '0);
    send_instr(ACT_NOP, 10'h3ff, 32'hffff_ffff);
    send_instr(ACT_SPARE, 10'd0, '0);

    // random: reads only ever touch words that a preload or store has set
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 300 && n < 500);
      roll = $urandom_range(0, 99);
      if (written_addrs.size() < 8 || roll < 6) begin
        act = ACT_PRELOAD;
      end else if (roll < 12) begin
        act = ACT_STORE;
      end else begin
        act = 4'($urandom_range(1, 15));
      end
      if (act == ACT_PRELOAD || act == ACT_STORE) begin
        addr = 10'($urandom_range(0, MEM_DEPTH_DEF - 1));
      end else begin
        addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      end
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = 32'h8000_0000;
        2:       value = 32'h7fff_ffff;
        3:       value = 32'hffff_ffff;
        4, 5:    value = 32'($urandom_range(0, 31)) - 32'd16;
        default: value = $urandom();
      endcase
      send_instr(act, addr, value);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // let the count of the last transfer settle before waiting on it
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // room for a stray late result to show up
    repeat (60) @(posedge clk_i);

    if (pending != 0) $error("%0d results never arrived", pending);
    $display("%0d instructions sent, %0d results checked, %0d zero-divisor divides",
             sent_count, result_count, div_zero_count);
    $display("covered all actions and the spare code, negate/abs/divide extremes, %0d-cycle %s",
             HOLD_CYCLES, "output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("ias_accumulator_execute test passed");
    end else begin
      $display("ias_accumulator_execute test failed");
    end
    $finish;
  end

endmodule
